FILE: rtl/core/bounded_array_list_macros.svh
// ---------------------------------------------------------------------------
// Bounded array list assertion macros
// Concurrent assertion helpers shared by the bounded array list RTL.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

// The condition must never be true outside reset.
`define BAL_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define BAL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define BAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bal_pkg.sv
// ---------------------------------------------------------------------------
// Bounded array list package
// Shared constants, operation codes and types of the bounded array list.
// ---------------------------------------------------------------------------
package bal_pkg;

   // Default number of entries the list can hold.
   localparam int CAPACITY_DEF = 16;

   // Width of the reported count; larger counts are reported modulo 32.
   localparam int COUNT_W = 5;

   // Request operation codes.
   localparam logic [1:0] MODE_APPEND       = 2'd0;
   localparam logic [1:0] MODE_REMOVE_FIRST = 2'd1;
   localparam logic [1:0] MODE_REMOVE_ALL   = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } bal_state_type;

   // Result of one request, handed from the sequencer to the output stage.
   typedef struct packed {
      logic               full_res;
      logic               empty_res;
      logic [COUNT_W-1:0] count;
      logic               ok;
   } bal_result_type;

endpackage

FILE: rtl/core/bal_ram.sv
// ---------------------------------------------------------------------------
// Bounded array list entry store
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bal_ram #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [$clog2((CAPACITY > 1) ? CAPACITY : 2)-1:0] wr_addr,
   input  logic [31:0]                                   wr_data,
   input  logic [$clog2((CAPACITY > 1) ? CAPACITY : 2)-1:0] rd_addr,
   output logic [31:0]                                   rd_data
);

   logic [31:0] mem_ff [CAPACITY];
   logic [31:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bal_ctrl.sv
// ---------------------------------------------------------------------------
// Bounded array list sequencer
// Runs append directly and walks the list for both remove modes, using one
// shared word comparator and one compaction write pointer.
// ---------------------------------------------------------------------------
module bal_ctrl #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request side.
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_mode,
   input  logic [31:0]             req_value,
   // Result side.
   output logic                    res_valid,
   input  logic                    res_take,
   output bal_pkg::bal_result_type res,
   // Entry store.
   output logic                    ram_we,
   output logic [$clog2((CAPACITY > 1) ? CAPACITY : 2)-1:0] ram_waddr,
   output logic [31:0]             ram_wdata,
   output logic [$clog2((CAPACITY > 1) ? CAPACITY : 2)-1:0] ram_raddr,
   input  logic [31:0]             ram_rdata
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > bal_pkg::COUNT_W) ? CW : bal_pkg::COUNT_W;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   bal_pkg::bal_state_type state_ff, state_in;
   logic [1:0]             mode_ff, mode_in;
   logic [31:0]            value_ff, value_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [CW-1:0]          rd_ff, rd_in;
   logic [CW-1:0]          wr_ff, wr_in;
   logic                   pend_ff, pend_in;
   logic                   found_ff, found_in;
   logic                   ok_ff, ok_in;
   logic                   match;
   logic [XW-1:0]          count_ext;

   // Shared comparator between the word just read and the request value.
   assign match = (ram_rdata == value_ff);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bal_pkg::ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      pend_ff  <= pend_in;
      found_ff <= found_in;
      ok_ff    <= ok_in;
   end

   // Next state and datapath control.
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      value_in  = value_ff;
      fill_in   = fill_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      pend_in   = pend_ff;
      found_in  = found_ff;
      ok_in     = ok_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = wr_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = rd_ff[AW-1:0];
      case (state_ff)
         bal_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               value_in = req_value;
               rd_in    = '0;
               wr_in    = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               ok_in    = 1'b0;
               case (req_mode)
                  bal_pkg::MODE_APPEND: begin
                     // Append writes the tail slot right away when there is room.
                     if (fill_ff != CAP_CNT) begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_ff[AW-1:0];
                        ram_wdata = req_value;
                        fill_in   = fill_ff + 1'b1;
                        ok_in     = 1'b1;
                     end
                     state_in = bal_pkg::ST_DONE;
                  end
                  bal_pkg::MODE_REMOVE_FIRST,
                  bal_pkg::MODE_REMOVE_ALL: begin
                     state_in = bal_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = bal_pkg::ST_DONE;
                  end
               endcase
            end
         end
         bal_pkg::ST_SCAN: begin
            // Word read last cycle: drop it or copy it down to the write pointer.
            if (pend_ff) begin
               if (match && ((mode_ff == bal_pkg::MODE_REMOVE_ALL) || !found_ff)) begin
                  found_in = 1'b1;
               end else begin
                  ram_we = 1'b1;
                  wr_in  = wr_ff + 1'b1;
               end
            end
            // Issue the next read while entries remain.
            if (rd_ff != fill_ff) begin
               rd_in   = rd_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  ok_in    = (wr_ff != fill_ff);
                  fill_in  = wr_ff;
                  state_in = bal_pkg::ST_DONE;
               end
            end
         end
         bal_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = bal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bal_pkg::ST_IDLE;
         end
      endcase
   end

   // The count, empty and full fields reflect the fill count after the request.
   assign count_ext     = XW'(fill_ff);
   assign res.ok        = ok_ff;
   assign res.count     = count_ext[bal_pkg::COUNT_W-1:0];
   assign res.empty_res = (fill_ff == '0);
   assign res.full_res  = (fill_ff == CAP_CNT);

endmodule

FILE: rtl/core/bounded_array_list.sv
// ---------------------------------------------------------------------------
// Bounded array list
// Ordered list of up to CAPACITY unsigned words with append, remove-first and
// remove-all requests; each request returns one status beat.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Contents
//   req_      in    tuser: mode, tdata: value
//   rsp_      out   tdata: ok, count, empty_res, full_res
//
// An append writes the tail slot in the cycle of its request beat. A remove
// walks the list with one read and one compare per entry, paced by the single
// read port of the entry store. One request is worked on at a time;
// req_tready is low until its result is handed to the output register, which
// then waits for rsp_tready. Reset clears the fill count; the entry store
// needs no clearing pass.
// ---------------------------------------------------------------------------
`include "bounded_array_list_macros.svh"

module bounded_array_list #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] ok, [5:1] count, [6] empty_res, [7] full_res
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   bal_pkg::bal_result_type res;
   logic                    res_valid;
   logic                    res_take;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [31:0]             ram_wdata;
   logic [AW-1:0]           ram_raddr;
   logic [31:0]             ram_rdata;
   logic                    rsp_valid_ff, rsp_valid_in;
   bal_pkg::bal_result_type rsp_data_ff, rsp_data_in;

   bal_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .req_value (req_tdata),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   bal_ram #(
      .CAPACITY (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The output register takes a result when it is empty or being drained.
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = res_take ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A list cannot be empty and full at the same time.
   `BAL_ASSERT_NEVER(a_empty_full, clock, reset, rsp_valid_ff && rsp_data_ff.empty_res && rsp_data_ff.full_res, "result is both empty and full")

   // The block is busy in the cycle after a request beat.
   `BAL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "ready again right after a request beat")

   // A result is only offered while no new request can be taken.
   `BAL_ASSERT_IMPLIES(a_res_not_idle, clock, reset, res_valid, !req_tready, "result offered while idle")

endmodule
